FILE: hdl/pfbm_pkg.sv
package pfbm_pkg;

  // stream and configuration port widths
  localparam int InDataWidth  = 88;
  localparam int OutDataWidth = 80;
  localparam int OutUserWidth = 2;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;

  // reciprocals for the two constant divisions, both exact over the magnitude range
  localparam int RecipShift = 16;
  localparam logic [11:0] KneeRecip = 12'd2428;  // ceil(2^16 / 27), knee = 2*dev / 27
  localparam logic [12:0] HipRecip  = 13'd6554;  // ceil(2^16 / 10), hip  = dev / 10

  localparam int IrSteps = 11;
  localparam logic [9:0] IR_THRESH [IrSteps] =
    '{10'd70, 10'd80, 10'd95, 10'd115, 10'd150, 10'd175, 10'd205, 10'd245, 10'd310,
      10'd455, 10'd625};
  localparam logic [6:0] IR_DIST [IrSteps] =
    '{7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5};

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_SIT      = 2'd1,
    ACT_BACK_UP  = 2'd2,
    ACT_FRONT_UP = 2'd3
  } action_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_BATTERY_CUTOFF = 3'd0,
    REG_SLIP_LIMIT     = 3'd1,
    REG_GYRO_X_CENTER  = 3'd2,
    REG_GYRO_Y_CENTER  = 3'd3,
    REG_ACCEL_X_CENTER = 3'd4,
    REG_ACCEL_Y_CENTER = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] battery_cutoff_mv;
    logic [9:0]  slip_limit;
    logic [9:0]  gyro_x_center;
    logic [9:0]  gyro_y_center;
    logic [12:0] accel_x_center;
    logic [12:0] accel_y_center;
  } cfg_t;

  typedef struct packed {
    logic [15:0] battery_mv;
    logic [9:0]  gyro_x_raw;
    logic [9:0]  gyro_y_raw;
    logic [12:0] accel_x_mv;
    logic [12:0] accel_y_mv;
    logic [12:0] sonar_mv;
    logic [9:0]  ir_range_raw;
  } frame_t;

  typedef struct packed {
    logic signed [7:0]  knee;
    logic signed [8:0]  ankle_pitch;
    logic signed [7:0]  hip_roll;
    logic signed [8:0]  ankle_roll;
    logic signed [13:0] accel_x;
    logic signed [13:0] accel_y;
    logic [10:0]        sonar;
    logic [6:0]         ir_range;
  } held_t;

  // step table: count thresholds at or below the reading, then pick the distance
  function automatic logic [6:0] ir_lookup(input logic [9:0] raw);
    logic [3:0] n;
    logic [6:0] d;
    n = 4'd0;
    for (int i = 0; i < IrSteps; i++) begin
      n = n + {3'd0, (raw >= IR_THRESH[i])};
    end
    if (n == 4'd0) begin
      d = IR_DIST[0];
    end else if (n >= 4'(IrSteps)) begin
      d = IR_DIST[IrSteps-1];
    end else begin
      d = IR_DIST[n];
    end
    return d;
  endfunction

endpackage

FILE: hdl/pfbm_calc.sv
module pfbm_calc (
  input  pfbm_pkg::frame_t  frame,
  input  pfbm_pkg::cfg_t    cfg,
  input  pfbm_pkg::held_t   held,
  output pfbm_pkg::action_t action,
  output pfbm_pkg::held_t   held_next
);
  import pfbm_pkg::*;

  logic signed [10:0] gx_dev;
  logic signed [10:0] gy_dev;
  logic signed [10:0] lim;
  logic signed [10:0] neg_lim;
  logic [9:0]         gx_mag;
  logic [9:0]         gy_mag;
  logic [22:0]        knee_prod;
  logic [22:0]        hip_prod;
  logic [6:0]         knee_q;
  logic [6:0]         hip_q;
  logic signed [7:0]  knee;
  logic signed [7:0]  hip;
  logic               low_batt;
  logic               slip_back;
  logic               slip_front;

  assign low_batt = frame.battery_mv < cfg.battery_cutoff_mv;

  assign gx_dev  = $signed({1'b0, frame.gyro_x_raw}) - $signed({1'b0, cfg.gyro_x_center});
  assign gy_dev  = $signed({1'b0, frame.gyro_y_raw}) - $signed({1'b0, cfg.gyro_y_center});
  assign lim     = $signed({1'b0, cfg.slip_limit});
  assign neg_lim = -lim;

  assign slip_back  = gx_dev > lim;
  assign slip_front = gx_dev < neg_lim;

  // truncating division on the magnitude, sign put back afterwards
  assign gx_mag = gx_dev[10] ? 10'(-gx_dev) : gx_dev[9:0];
  assign gy_mag = gy_dev[10] ? 10'(-gy_dev) : gy_dev[9:0];

  assign knee_prod = {gx_mag, 1'b0} * KneeRecip;
  assign hip_prod  = {3'd0, gy_mag} * HipRecip;
  assign knee_q    = knee_prod[RecipShift +: 7];
  assign hip_q     = hip_prod[RecipShift +: 7];

  assign knee = gx_dev[10] ? -$signed({1'b0, knee_q}) : $signed({1'b0, knee_q});
  assign hip  = gy_dev[10] ? -$signed({1'b0, hip_q})  : $signed({1'b0, hip_q});

  always_comb begin
    held_next = held;
    action    = ACT_NONE;
    if (low_batt) begin
      action = ACT_SIT;
    end else begin
      held_next.accel_x  = $signed({1'b0, frame.accel_x_mv}) - $signed({1'b0, cfg.accel_x_center});
      held_next.accel_y  = $signed({1'b0, frame.accel_y_mv}) - $signed({1'b0, cfg.accel_y_center});
      held_next.sonar    = frame.sonar_mv[12:2];
      held_next.ir_range = ir_lookup(frame.ir_range_raw);
      if (slip_back) begin
        action = ACT_BACK_UP;
      end else if (slip_front) begin
        action = ACT_FRONT_UP;
      end else begin
        held_next.knee        = knee;
        held_next.ankle_pitch = $signed({knee[7], knee}) + $signed({knee, 1'b0});
        held_next.hip_roll    = hip;
        held_next.ankle_roll  = $signed({hip, 1'b0});
      end
    end
  end

endmodule

FILE: hdl/posture_fall_and_balance_monitor.sv
// Posture fall and balance monitor. Each sensor frame on the slave stream yields one result
// item on the master stream: the action code (tuser) and the held offsets and distances
// (tdata). A frame with battery below battery_cutoff_mv gives action sit and repeats the held
// values; a gyro x deviation beyond +/- slip_limit gives a back or front get-up action and
// keeps the old balance offsets while accelerometer and distance values still update. A new
// frame is taken every clock cycle unless m_tready stalls, a single-cycle rate set by the
// one-step datapath from the input register to the result register, which is the held
// state itself; back-pressure from m_tready reaches s_tready through the input register.
// The user must write configuration registers through cfg_wr_en, cfg_index and cfg_wdata
// only while no frame is in flight (not enforced); indexes beyond the list are ignored.
module posture_fall_and_balance_monitor (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_wr_en,
  input  logic [pfbm_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [pfbm_pkg::CfgDataWidth-1:0]     cfg_wdata,
  // sensor frames
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // battery_mv, gyro_x_raw, gyro_y_raw, accel_x_mv, accel_y_mv, sonar_mv, ir_range_raw,
  // zero fill
  input  logic [pfbm_pkg::InDataWidth-1:0]      s_tdata,
  // results
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // knee_offset, ankle_pitch_offset, hip_roll_offset, ankle_roll_offset, accel_x_dev,
  // accel_y_dev, sonar_cm, ir_range_cm
  output logic [pfbm_pkg::OutDataWidth-1:0]     m_tdata,
  // action
  output logic [pfbm_pkg::OutUserWidth-1:0]     m_tuser
);
  import pfbm_pkg::*;

  cfg_t    cfg;
  frame_t  s1_frame;
  logic    s1_valid;
  logic    s1_adv;
  held_t   held;
  held_t   held_next;
  action_t calc_action;
  action_t action;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_cutoff_mv <= 16'd0;
      cfg.slip_limit        <= 10'd1023;
      cfg.gyro_x_center     <= 10'd512;
      cfg.gyro_y_center     <= 10'd512;
      cfg.accel_x_center    <= 13'd2500;
      cfg.accel_y_center    <= 13'd2500;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BATTERY_CUTOFF: cfg.battery_cutoff_mv <= cfg_wdata;
        REG_SLIP_LIMIT:     cfg.slip_limit        <= cfg_wdata[9:0];
        REG_GYRO_X_CENTER:  cfg.gyro_x_center     <= cfg_wdata[9:0];
        REG_GYRO_Y_CENTER:  cfg.gyro_y_center     <= cfg_wdata[9:0];
        REG_ACCEL_X_CENTER: cfg.accel_x_center    <= cfg_wdata[12:0];
        REG_ACCEL_Y_CENTER: cfg.accel_y_center    <= cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // input register moves on when the result register is free or being drained
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  // frame fields unpacked from the lowest bit up
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_frame.battery_mv   <= s_tdata[15:0];
      s1_frame.gyro_x_raw   <= s_tdata[25:16];
      s1_frame.gyro_y_raw   <= s_tdata[35:26];
      s1_frame.accel_x_mv   <= s_tdata[48:36];
      s1_frame.accel_y_mv   <= s_tdata[61:49];
      s1_frame.sonar_mv     <= s_tdata[74:62];
      s1_frame.ir_range_raw <= s_tdata[84:75];
    end
  end

  pfbm_calc u_calc (
    .frame     (s1_frame),
    .cfg       (cfg),
    .held      (held),
    .action    (calc_action),
    .held_next (held_next)
  );

  // held state doubles as the result register: it only changes when a result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      m_tvalid <= 1'b0;
      action   <= ACT_NONE;
    end else begin
      if (s1_adv) begin
        held     <= held_next;
        action   <= calc_action;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tuser = action;
  assign m_tdata = {held.ir_range, held.sonar, held.accel_y, held.accel_x,
                    held.ankle_roll, held.hip_roll, held.ankle_pitch, held.knee};

  // low battery leaves every held value alone
  a_sit_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && calc_action == ACT_SIT) |=> $stable(held))
    else $error("held state changed on a low battery item");

  // get-up keeps the balance offsets
  a_getup_keeps_offsets: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (calc_action == ACT_BACK_UP || calc_action == ACT_FRONT_UP))
      |=> ($stable(held.knee) && $stable(held.hip_roll)))
    else $error("balance offsets changed on a get-up item");

  // ankle offsets stay tied to the knee and hip offsets
  a_offset_ratio: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (held.ankle_pitch == ($signed({held.knee[7], held.knee})
                                       + $signed({held.knee, 1'b0}))
                  && held.ankle_roll == $signed({held.hip_roll, 1'b0})))
    else $error("ankle offsets out of ratio");

  // a stalled item in the input register is neither lost nor overwritten
  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_frame)))
    else $error("stalled item lost in the input register");

endmodule

FILE: verif/posture_fall_and_balance_monitor_test.sv
module posture_fall_and_balance_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfbm_pkg::*;

  // run limit in clock cycles, far above the slowest legal run
  localparam int CycleLimit = 200000;
  // receiver hold-off length for the back-pressure test
  localparam int HoldCycles = 300;
  // cycles after the last result, covering the two-stage pipe
  localparam int SettleCycles = 10;

  // register indexes past the end of the list, which the block ignores
  localparam logic [CfgIdxWidth-1:0] RegSpareLow  = 3'd6;
  localparam logic [CfgIdxWidth-1:0] RegSpareHigh = 3'd7;

  // infrared step table, rising thresholds and falling distances
  localparam int IrThresholds [11] = '{70, 80, 95, 115, 150, 175, 205, 245, 310, 455, 625};
  localparam int IrDistances  [11] = '{80, 70, 60, 50, 40, 30, 25, 20, 15, 10, 5};

  // one sensor frame as it travels on the input stream
  typedef struct {
    logic [15:0] battery;
    logic [9:0]  gyro_x;
    logic [9:0]  gyro_y;
    logic [12:0] accel_x;
    logic [12:0] accel_y;
    logic [12:0] sonar;
    logic [9:0]  ir;
  } sensor_frame_t;

  // held posture values, which are also the result fields
  typedef struct {
    logic signed [7:0]  knee;
    logic signed [8:0]  ankle_pitch;
    logic signed [7:0]  hip_roll;
    logic signed [8:0]  ankle_roll;
    logic signed [13:0] accel_x;
    logic signed [13:0] accel_y;
    logic [10:0]        sonar;
    logic [6:0]         ir_range;
  } posture_vals_t;

  typedef struct {
    action_t       action;
    posture_vals_t vals;
  } posture_result_t;

  // monitor settings as the block should hold them
  typedef struct {
    int cutoff;
    int slip;
    int gx_center;
    int gy_center;
    int ax_center;
    int ay_center;
  } monitor_cfg_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;
  logic [OutUserWidth-1:0] m_tuser;

  monitor_cfg_t    cfg_model;
  posture_vals_t   held_model;
  posture_result_t pending_results [$];

  int errors = 0;
  int cycle_count = 0;
  // random idling on both sides, switched off for the long clean stretch
  bit gaps_on = 1'b1;
  // receiver hold-off request and its countdown
  bit rx_hold_request = 1'b0;
  int rx_hold_left = 0;

  posture_fall_and_balance_monitor i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #2 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("posture_fall_and_balance_monitor_test: done, errors");
      $finish;
    end
  end

  // distance in cm from the step table
  function automatic logic [6:0] ir_distance_cm(input logic [9:0] raw);
    int n;
    n = 0;
    while (n < 11 && int'(raw) >= IrThresholds[n]) begin
      n++;
    end
    if (n == 0) begin
      return 7'(IrDistances[0]);
    end else if (n >= 11) begin
      return 7'(IrDistances[10]);
    end
    return 7'(IrDistances[n]);
  endfunction

  // expected result of one accepted frame, advancing the held values
  function automatic posture_result_t predict_posture(input sensor_frame_t f);
    posture_result_t r;
    int gx_dev;
    int gy_dev;
    int knee;
    int hip;
    if (int'(f.battery) < cfg_model.cutoff) begin
      // low battery: sit and repeat everything held
      r.action = ACT_SIT;
    end else begin
      gx_dev = int'(f.gyro_x) - cfg_model.gx_center;
      gy_dev = int'(f.gyro_y) - cfg_model.gy_center;
      held_model.accel_x = 14'(int'(f.accel_x) - cfg_model.ax_center);
      held_model.accel_y = 14'(int'(f.accel_y) - cfg_model.ay_center);
      held_model.sonar = 11'(f.sonar >> 2);
      held_model.ir_range = ir_distance_cm(f.ir);
      if (gx_dev > cfg_model.slip) begin
        r.action = ACT_BACK_UP;
      end else if (gx_dev < -cfg_model.slip) begin
        r.action = ACT_FRONT_UP;
      end else begin
        // int division truncates toward zero
        r.action = ACT_NONE;
        knee = (gx_dev * 4) / 54;
        hip = (gy_dev * 4) / 40;
        held_model.knee = 8'(knee);
        held_model.ankle_pitch = 9'(knee * 3);
        held_model.hip_roll = 8'(hip);
        held_model.ankle_roll = 9'(hip * 2);
      end
    end
    r.vals = held_model;
    return r;
  endfunction

  function automatic sensor_frame_t make_frame(input int battery, input int gx, input int gy,
                                               input int ax, input int ay, input int sonar,
                                               input int ir);
    sensor_frame_t f;
    f.battery = 16'(battery);
    f.gyro_x = 10'(gx);
    f.gyro_y = 10'(gy);
    f.accel_x = 13'(ax);
    f.accel_y = 13'(ay);
    f.sonar = 13'(sonar);
    f.ir = 10'(ir);
    return f;
  endfunction

  // mostly frames near the interesting boundaries of the current settings
  function automatic sensor_frame_t random_frame();
    sensor_frame_t f;
    int sel;
    int gx;
    sel = int'($urandom_range(99));
    if (cfg_model.cutoff > 0 && sel < 10) begin
      f.battery = 16'($urandom_range(cfg_model.cutoff - 1));
    end else begin
      f.battery = 16'($urandom_range(65535, cfg_model.cutoff));
    end
    sel = int'($urandom_range(99));
    if (sel < 35) begin
      gx = int'($urandom_range(1023));
    end else if (sel < 75) begin
      gx = cfg_model.gx_center + int'($urandom_range(2 * cfg_model.slip)) - cfg_model.slip;
    end else if (sel < 88) begin
      gx = cfg_model.gx_center + cfg_model.slip + int'($urandom_range(1, 20));
    end else begin
      gx = cfg_model.gx_center - cfg_model.slip - int'($urandom_range(1, 20));
    end
    if (gx < 0) gx = 0;
    if (gx > 1023) gx = 1023;
    f.gyro_x = 10'(gx);
    f.gyro_y = 10'($urandom);
    f.accel_x = 13'($urandom);
    f.accel_y = 13'($urandom);
    f.sonar = 13'($urandom);
    if ($urandom_range(99) < 30) begin
      // just around a table step
      f.ir = 10'(IrThresholds[$urandom_range(10)] + int'($urandom_range(2)) - 1);
    end else begin
      f.ir = 10'($urandom);
    end
    return f;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result checker: every result item against the oldest expectation
  always @(posedge clk) begin
    posture_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual tuser %0h tdata %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("action", 16'(want.action), 16'(m_tuser));
        check_field("knee_offset", 16'($unsigned(want.vals.knee)), 16'(m_tdata[7:0]));
        check_field("ankle_pitch_offset", 16'($unsigned(want.vals.ankle_pitch)),
                    16'(m_tdata[16:8]));
        check_field("hip_roll_offset", 16'($unsigned(want.vals.hip_roll)),
                    16'(m_tdata[24:17]));
        check_field("ankle_roll_offset", 16'($unsigned(want.vals.ankle_roll)),
                    16'(m_tdata[33:25]));
        check_field("accel_x_dev", 16'($unsigned(want.vals.accel_x)), 16'(m_tdata[47:34]));
        check_field("accel_y_dev", 16'($unsigned(want.vals.accel_y)), 16'(m_tdata[61:48]));
        check_field("sonar_cm", 16'(want.vals.sonar), 16'(m_tdata[72:62]));
        check_field("ir_range_cm", 16'(want.vals.ir_range), 16'(m_tdata[79:73]));
      end
    end
  end

  // receiver: random stalls, or a long counted hold-off on request
  always @(negedge clk) begin
    if (rx_hold_request) begin
      rx_hold_request = 1'b0;
      rx_hold_left = HoldCycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(gaps_on && $urandom_range(99) < 7);
    end
  end

  // offer one frame, wait for acceptance, record its expected result
  task automatic send_frame(input sensor_frame_t f);
    if (gaps_on && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, f.ir, f.sonar, f.accel_y, f.accel_x, f.gyro_y, f.gyro_x, f.battery};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_posture(f));
    @(negedge clk);
  endtask

  // stop sending and let every expected result come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // one register write, only while the block is idle
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_BATTERY_CUTOFF: cfg_model.cutoff = int'(value);
      REG_SLIP_LIMIT:     cfg_model.slip = int'(value[9:0]);
      REG_GYRO_X_CENTER:  cfg_model.gx_center = int'(value[9:0]);
      REG_GYRO_Y_CENTER:  cfg_model.gy_center = int'(value[9:0]);
      REG_ACCEL_X_CENTER: cfg_model.ax_center = int'(value[12:0]);
      REG_ACCEL_Y_CENTER: cfg_model.ay_center = int'(value[12:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all_regs(input int cutoff, input int slip, input int gxc, input int gyc,
                              input int axc, input int ayc);
    drain_results();
    write_reg(REG_BATTERY_CUTOFF, 16'(cutoff));
    write_reg(REG_SLIP_LIMIT, 16'(slip));
    write_reg(REG_GYRO_X_CENTER, 16'(gxc));
    write_reg(REG_GYRO_Y_CENTER, 16'(gyc));
    write_reg(REG_ACCEL_X_CENTER, 16'(axc));
    write_reg(REG_ACCEL_Y_CENTER, 16'(ayc));
  endtask

  // sit straight after reset repeats the zero held values, then the cutoff boundary
  task automatic test_low_battery();
    drain_results();
    write_reg(REG_BATTERY_CUTOFF, 16'hFFFF);
    send_frame(make_frame(0, 700, 300, 4000, 1000, 5000, 500));
    send_frame(make_frame(65535, 700, 300, 4000, 1000, 5000, 500));
    drain_results();
    write_reg(REG_BATTERY_CUTOFF, 16'd1000);
    send_frame(make_frame(999, 100, 900, 0, 8191, 123, 60));
    send_frame(make_frame(1000, 520, 500, 2600, 2400, 8191, 1023));
  endtask

  // gyro x deviation just inside and just past the slip limit on both sides
  task automatic test_slip_limits();
    set_all_regs(0, 100, 512, 512, 2500, 2500);
    send_frame(make_frame(5000, 613, 1000, 2000, 3000, 400, 200));
    send_frame(make_frame(5000, 612, 20, 2100, 3100, 404, 210));
    send_frame(make_frame(5000, 411, 700, 2200, 3200, 408, 220));
    send_frame(make_frame(5000, 412, 300, 2300, 3300, 412, 230));
    drain_results();
    write_reg(REG_SLIP_LIMIT, 16'd0);
    send_frame(make_frame(5000, 512, 512, 2500, 2500, 0, 0));
    send_frame(make_frame(5000, 513, 600, 2501, 2499, 3, 69));
    send_frame(make_frame(5000, 511, 400, 2499, 2501, 4, 70));
  endtask

  // largest deviations both ways, and register writes with bits past the width
  task automatic test_field_extremes();
    set_all_regs(0, 1023, 0, 0, 0, 0);
    send_frame(make_frame(65535, 1023, 1023, 8191, 8191, 8191, 1023));
    drain_results();
    write_reg(REG_GYRO_X_CENTER, 16'hFFFF);
    write_reg(REG_GYRO_Y_CENTER, 16'hFFFF);
    write_reg(REG_ACCEL_X_CENTER, 16'hFFFF);
    write_reg(REG_ACCEL_Y_CENTER, 16'hFFFF);
    write_reg(REG_SLIP_LIMIT, 16'hFFFF);
    // spare indexes must leave every register alone
    write_reg(RegSpareLow, 16'hFFFF);
    write_reg(RegSpareHigh, 16'h0000);
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 0));
    drain_results();
    write_reg(REG_GYRO_X_CENTER, 16'hFC00);
    write_reg(REG_ACCEL_X_CENTER, 16'hE000);
    send_frame(make_frame(1, 1023, 0, 8191, 0, 1, 1));
  endtask

  // each step of the infrared table plus the bottom of the range
  task automatic test_ir_steps();
    set_all_regs(0, 1023, 512, 512, 2500, 2500);
    send_frame(make_frame(4000, 512, 512, 2500, 2500, 100, 0));
    for (int i = 0; i < 11; i++) begin
      send_frame(make_frame(4000, 512, 512, 2500, 2500, 100, IrThresholds[i]));
    end
  endtask

  // random frames over a spread of settings, one phase without any idling
  task automatic test_random_phases();
    int cutoff;
    int slip;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_all_regs(0, 1023, 512, 512, 2500, 2500);
        1: set_all_regs(65535, 1023, 512, 512, 2500, 2500);
        2: set_all_regs(0, 0, 0, 0, 0, 0);
        3: set_all_regs(3000, 50, 1023, 1023, 8191, 8191);
        default: begin
          cutoff = int'($urandom_range(4000));
          slip = int'($urandom_range(300));
          set_all_regs(cutoff, slip, int'($urandom_range(1023)), int'($urandom_range(1023)),
                       int'($urandom_range(8191)), int'($urandom_range(8191)));
        end
      endcase
      gaps_on = (phase != 5);
      repeat (100) send_frame(random_frame());
      gaps_on = 1'b1;
    end
  endtask

  // receiver holds off long enough to fill the pipe while frames keep coming
  task automatic test_back_pressure();
    set_all_regs(1500, 80, 500, 520, 2400, 2600);
    rx_hold_request = 1'b1;
    repeat (30) send_frame(random_frame());
  endtask

  // sender goes quiet until every result is out, then carries on
  task automatic test_sender_pause();
    repeat (10) send_frame(random_frame());
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) send_frame(random_frame());
  endtask

  initial begin
    cfg_model = '{cutoff: 0, slip: 1023, gx_center: 512, gy_center: 512,
                  ax_center: 2500, ay_center: 2500};
    held_model = '{default: '0};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_low_battery();
    test_slip_limits();
    test_field_extremes();
    test_ir_steps();
    test_random_phases();
    test_back_pressure();
    test_sender_pause();

    drain_results();
    if (errors == 0) begin
      $display("posture_fall_and_balance_monitor_test: done, clean");
    end else begin
      $display("posture_fall_and_balance_monitor_test: done, errors");
    end
    $finish;
  end

endmodule
